>>> design/arima_inverse_iir_filter_macros.svh
// ----------------------------------------------------------------------------
// ARIMA inverse filter assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ARIMA_INVERSE_IIR_FILTER_MACROS_SVH
`define ARIMA_INVERSE_IIR_FILTER_MACROS_SVH

// checked only while out of reset
`define AIIF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define AIIF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/aiif_pkg.sv
// ----------------------------------------------------------------------------
// aiif_pkg
// Widths, register indexes and types of the ARIMA inverse filter.
// ----------------------------------------------------------------------------
package aiif_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = 18;
    localparam int OUT_W      = 24;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int AR_TAPS    = 3;
    localparam int MA_TAPS    = 3;
    localparam int MAX_DIFF   = 2;
    localparam int ORDER_W    = 2;
    localparam int AR_PROD_W  = COEF_W + DIFF_W;
    localparam int MA_PROD_W  = COEF_W + OUT_W;
    localparam int ACC_W      = MA_PROD_W + 4;
    localparam int YFULL_W    = ACC_W - FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_DIFF_ORDER = 3'd0;
    localparam t_cfg_idx REG_AR_COEF_1  = 3'd1;
    localparam t_cfg_idx REG_AR_COEF_2  = 3'd2;
    localparam t_cfg_idx REG_AR_COEF_3  = 3'd3;
    localparam t_cfg_idx REG_MA_COEF_1  = 3'd4;
    localparam t_cfg_idx REG_MA_COEF_2  = 3'd5;
    localparam t_cfg_idx REG_MA_COEF_3  = 3'd6;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;

endpackage

>>> design/arima_inverse_iir_filter.sv
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle while the result is not stalled; the AR/MA sum and output feedback are combinational.
// A stalled result register holds the input register, which then stalls the input side.
// Reset (i_rst_n low, synchronous): coefficients, difference order and all history go to
// zero and both pipeline registers go empty.
// ----------------------------------------------------------------------------
// arima_inverse_iir_filter
// Difference passes followed by a three-tap AR / three-tap MA inverse filter,
// Q2.14 coefficients, rounded and saturated to 24 bits.
// ----------------------------------------------------------------------------
module arima_inverse_iir_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aiif_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aiif_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [aiif_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                            i_series_start,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [aiif_pkg::OUT_W-1:0] o_filtered,
    output logic                            o_clipped
);

    // configuration
    logic [aiif_pkg::ORDER_W-1:0] r_diff_order;
    aiif_pkg::t_coef              r_ar [aiif_pkg::AR_TAPS];
    aiif_pkg::t_coef              r_ma [aiif_pkg::MA_TAPS];

    // history
    aiif_pkg::t_diff r_diff_prev [aiif_pkg::MAX_DIFF];
    aiif_pkg::t_diff r_x_hist    [aiif_pkg::AR_TAPS];
    aiif_pkg::t_out  r_y_hist    [aiif_pkg::MA_TAPS];

    // input register
    logic              r_in_valid;
    aiif_pkg::t_sample r_sample;
    logic              r_start;

    // result register
    logic              r_out_valid;
    aiif_pkg::t_out    r_filtered;
    logic              r_clipped;

    logic out_ready;
    logic fire;
    logic in_accept;

    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign in_accept = i_valid && !o_stall;
    assign o_stall   = r_in_valid && !out_ready;

    // datapath
    aiif_pkg::t_diff dp0, dp1, s_ext, d1, d2, x;
    aiif_pkg::t_diff xh [aiif_pkg::AR_TAPS];
    aiif_pkg::t_out  yh [aiif_pkg::MA_TAPS];
    logic [aiif_pkg::ORDER_W-1:0] order;
    logic signed [aiif_pkg::AR_PROD_W-1:0] p_ar [aiif_pkg::AR_TAPS];
    logic signed [aiif_pkg::MA_PROD_W-1:0] p_ma [aiif_pkg::MA_TAPS];
    aiif_pkg::t_acc acc, rnd;
    logic signed [aiif_pkg::YFULL_W-1:0] y_full;
    aiif_pkg::t_out  y;
    logic            clip;
    logic            fits;
    aiif_pkg::t_diff n_diff_prev [aiif_pkg::MAX_DIFF];

    always_comb begin
        // a series start sees zero history
        dp0   = r_start ? '0 : r_diff_prev[0];
        dp1   = r_start ? '0 : r_diff_prev[1];
        s_ext = aiif_pkg::DIFF_W'(r_sample);
        d1    = s_ext - dp0;
        d2    = d1 - dp1;
        order = (r_diff_order > aiif_pkg::ORDER_W'(aiif_pkg::MAX_DIFF))
              ? aiif_pkg::ORDER_W'(aiif_pkg::MAX_DIFF) : r_diff_order;
        case (order)
            2'd0:    x = s_ext;
            2'd1:    x = d1;
            default: x = d2;
        endcase
        n_diff_prev[0] = (order >= 2'd1) ? s_ext : dp0;
        n_diff_prev[1] = (order >= 2'd2) ? d1 : dp1;

        acc = aiif_pkg::t_acc'(x) <<< aiif_pkg::FRAC_BITS;
        for (int k = 0; k < aiif_pkg::AR_TAPS; k++) begin
            xh[k]   = r_start ? '0 : r_x_hist[k];
            p_ar[k] = r_ar[k] * xh[k];
            acc     = acc - aiif_pkg::t_acc'(p_ar[k]);
        end
        for (int k = 0; k < aiif_pkg::MA_TAPS; k++) begin
            yh[k]   = r_start ? '0 : r_y_hist[k];
            p_ma[k] = r_ma[k] * yh[k];
            acc     = acc - aiif_pkg::t_acc'(p_ma[k]);
        end

        // round half up, then floor shift
        rnd    = acc + (aiif_pkg::t_acc'(1) <<< (aiif_pkg::FRAC_BITS - 1));
        y_full = rnd[aiif_pkg::ACC_W-1:aiif_pkg::FRAC_BITS];
        fits   = (y_full[aiif_pkg::YFULL_W-1:aiif_pkg::OUT_W-1] == '0) ||
                 (y_full[aiif_pkg::YFULL_W-1:aiif_pkg::OUT_W-1] == '1);
        clip   = !fits;
        if (fits) begin
            y = y_full[aiif_pkg::OUT_W-1:0];
        end else if (y_full[aiif_pkg::YFULL_W-1]) begin
            y = {1'b1, {(aiif_pkg::OUT_W-1){1'b0}}};
        end else begin
            y = {1'b0, {(aiif_pkg::OUT_W-1){1'b1}}};
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_order <= '0;
            for (int k = 0; k < aiif_pkg::AR_TAPS; k++) r_ar[k] <= '0;
            for (int k = 0; k < aiif_pkg::MA_TAPS; k++) r_ma[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aiif_pkg::REG_DIFF_ORDER: r_diff_order <= i_cfg_data[aiif_pkg::ORDER_W-1:0];
                aiif_pkg::REG_AR_COEF_1:  r_ar[0] <= i_cfg_data;
                aiif_pkg::REG_AR_COEF_2:  r_ar[1] <= i_cfg_data;
                aiif_pkg::REG_AR_COEF_3:  r_ar[2] <= i_cfg_data;
                aiif_pkg::REG_MA_COEF_1:  r_ma[0] <= i_cfg_data;
                aiif_pkg::REG_MA_COEF_2:  r_ma[1] <= i_cfg_data;
                aiif_pkg::REG_MA_COEF_3:  r_ma[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < aiif_pkg::MAX_DIFF; k++) r_diff_prev[k] <= '0;
            for (int k = 0; k < aiif_pkg::AR_TAPS; k++)  r_x_hist[k] <= '0;
            for (int k = 0; k < aiif_pkg::MA_TAPS; k++)  r_y_hist[k] <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                for (int k = 0; k < aiif_pkg::MAX_DIFF; k++) r_diff_prev[k] <= n_diff_prev[k];
                r_x_hist[0] <= x;
                for (int k = 1; k < aiif_pkg::AR_TAPS; k++) r_x_hist[k] <= xh[k-1];
                r_y_hist[0] <= y;
                for (int k = 1; k < aiif_pkg::MA_TAPS; k++) r_y_hist[k] <= yh[k-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
            r_start  <= i_series_start;
        end
        if (fire) begin
            r_filtered <= y;
            r_clipped  <= clip;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_filtered;
    assign o_clipped  = r_clipped;

endmodule

>>> design/aiif_checker.sv
// ----------------------------------------------------------------------------
// aiif_checker
// Port-level checks of the ARIMA inverse filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "arima_inverse_iir_filter_macros.svh"

module aiif_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [aiif_pkg::OUT_W-1:0]   o_filtered,
    input logic                                o_clipped
);

    `AIIF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result valid right after reset")

    `AIIF_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_filtered) && $stable(o_clipped), "stalled result changed")

    `AIIF_ASSERT(a_clip_extreme, o_valid && o_clipped |-> (o_filtered == {1'b0, {(aiif_pkg::OUT_W-1){1'b1}}}) || (o_filtered == {1'b1, {(aiif_pkg::OUT_W-1){1'b0}}}), "clipped item not at a rail")

    `AIIF_ASSERT(a_latency, (i_valid && !o_stall) ##1 !i_stall |=> o_valid, "accepted item did not reach output in two cycles")

    `AIIF_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without a stalled result")

endmodule

bind arima_inverse_iir_filter aiif_checker u_aiif_checker (.*);

>>> bench/arima_inverse_iir_filter_tb.sv
// ----------------------------------------------------------------------------
// arima_inverse_iir_filter_tb
// Self-checking bench for the ARIMA inverse filter. A cycle-free predictor
// tracks differencing, AR/MA history, rounding and saturation per item, and
// every result is compared against it in order. Directed items cover the
// sample and coefficient extremes, rounding ties, clipping both ways and
// difference order clamping. Random series follow, under several settings
// and four handshake patterns.
// ----------------------------------------------------------------------------
module arima_inverse_iir_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aiif_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_ITEMS   = 156;
    localparam int NUM_REGS        = 7;
    localparam int MAX_RUN         = 40;

    localparam t_cfg_idx REG_UNMAPPED = 3'd7;

    localparam longint OUT_MAX_VAL = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN_VAL = -(longint'(1) <<< (OUT_W - 1));

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;
    localparam logic [CFG_DATA_W-1:0] COEF_MAX  = 16'h7FFF;
    localparam logic [CFG_DATA_W-1:0] COEF_MIN  = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] COEF_HALF = 16'h2000;

    typedef struct {
        t_out filtered;
        logic clipped;
    } filter_out_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    t_cfg_idx              i_cfg_idx      = REG_DIFF_ORDER;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    t_sample               i_sample       = '0;
    logic                  i_series_start = 1'b0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    t_out                  o_filtered;
    logic                  o_clipped;

    // predictor copy of the registers and history
    int unsigned order_reg = 0;
    longint      ar_gain  [AR_TAPS]  = '{default: 0};
    longint      ma_gain  [MA_TAPS]  = '{default: 0};
    longint      diff_mem [MAX_DIFF] = '{default: 0};
    longint      x_hist   [AR_TAPS]  = '{default: 0};
    longint      y_hist   [MA_TAPS]  = '{default: 0};

    logic [CFG_DATA_W-1:0] reg_image [NUM_REGS];
    filter_out_t           pending_outputs [$];

    int unsigned send_idle_pct   = 0;
    int unsigned stall_pct       = 0;
    int          fail_count      = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          clipped_seen    = 0;
    int          configs_loaded  = 0;
    int          quiet_cycles    = 0;

    arima_inverse_iir_filter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_series_start (i_series_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered     (o_filtered),
        .o_clipped      (o_clipped)
    );

    always #2 i_clk = ~i_clk;

    function automatic void note_reg_write(input t_cfg_idx idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DIFF_ORDER: begin
                order_reg = 32'(data[ORDER_W-1:0]);
            end
            REG_AR_COEF_1, REG_AR_COEF_2, REG_AR_COEF_3: begin
                ar_gain[idx - REG_AR_COEF_1] = longint'(signed'(data));
            end
            REG_MA_COEF_1, REG_MA_COEF_2, REG_MA_COEF_3: begin
                ma_gain[idx - REG_MA_COEF_1] = longint'(signed'(data));
            end
            default: begin
            end
        endcase
    endfunction

    // one item through difference passes, AR/MA sum, round and clamp
    function automatic filter_out_t inverse_filter_step(input t_sample s, input logic start);
        longint      x;
        longint      cur;
        longint      acc;
        longint      y;
        int unsigned passes;
        filter_out_t r;
        if (start) begin
            diff_mem = '{default: 0};
            x_hist   = '{default: 0};
            y_hist   = '{default: 0};
        end
        x = longint'(s);
        passes = (order_reg > 32'(MAX_DIFF)) ? 32'(MAX_DIFF) : order_reg;
        for (int unsigned k = 0; k < passes; k++) begin
            cur = x;
            x = cur - diff_mem[k];
            diff_mem[k] = cur;
        end
        acc = x <<< FRAC_BITS;
        for (int k = 0; k < AR_TAPS; k++) begin
            acc -= ar_gain[k] * x_hist[k];
        end
        for (int k = 0; k < MA_TAPS; k++) begin
            acc -= ma_gain[k] * y_hist[k];
        end
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.clipped = 1'b0;
        if (y > OUT_MAX_VAL) begin
            y = OUT_MAX_VAL;
            r.clipped = 1'b1;
        end else if (y < OUT_MIN_VAL) begin
            y = OUT_MIN_VAL;
            r.clipped = 1'b1;
        end
        for (int k = AR_TAPS - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k - 1];
        end
        x_hist[0] = x;
        for (int k = MA_TAPS - 1; k > 0; k--) begin
            y_hist[k] = y_hist[k - 1];
        end
        y_hist[0] = y;       // feedback uses the clamped value
        r.filtered = OUT_W'(y);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef(input int seg);
        case (seg)
            0: begin
                return COEF_MIN;
            end
            1: begin
                return COEF_MAX;
            end
            default: begin
            end
        endcase
        case ($urandom_range(3))
            0: begin
                return CFG_DATA_W'($urandom);
            end
            1: begin
                return CFG_DATA_W'($urandom_range(8192)) - 16'd4096;
            end
            2: begin
                return ($urandom_range(1) != 0) ? COEF_MAX : COEF_MIN;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0: begin
                return SAMPLE_MAX;
            end
            1: begin
                return SAMPLE_MIN;
            end
            2: begin
                return t_sample'(SAMPLE_W'($urandom_range(128)) - 16'd64);
            end
            default: begin
                return t_sample'(SAMPLE_W'($urandom));
            end
        endcase
    endfunction

    // writes reg_image to all registers, then a stray write to the unmapped index
    task automatic program_filter();
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(REG_DIFF_ORDER + i);
            i_cfg_data <= reg_image[i];
            note_reg_write(t_cfg_idx'(REG_DIFF_ORDER + i), reg_image[i]);
            @(posedge i_clk);
        end
        i_cfg_idx  <= REG_UNMAPPED;
        i_cfg_data <= junk;
        note_reg_write(REG_UNMAPPED, junk);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        configs_loaded++;
    endtask

    task automatic send_sample(input t_sample s, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample       <= s;
        i_series_start <= start;
        pending_outputs.push_back(inverse_filter_step(s, start));
        items_sent++;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // zero coefficients, no differencing: output equals the sample
    task automatic test_passthrough();
        reg_image = '{default: '0};
        program_filter();
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        wait_idle();
    endtask

    // half-LSB ties after the shift must round up
    task automatic test_rounding_ties();
        reg_image = '{default: '0};
        reg_image[REG_AR_COEF_1] = COEF_HALF;
        program_filter();
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd0, 1'b0);
        wait_idle();
    endtask

    // alternating full-scale input with max gains drives the output into both rails
    task automatic test_saturation();
        reg_image = '{default: COEF_MAX};
        reg_image[REG_DIFF_ORDER] = 16'd2;
        program_filter();
        for (int n = 0; n < 8; n++) begin
            send_sample((n % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, (n == 0));
        end
        wait_idle();
    endtask

    // order 3 clamps to two passes; high data bits are dropped
    task automatic test_difference_orders();
        reg_image = '{default: '0};
        reg_image[REG_DIFF_ORDER] = 16'd3;
        program_filter();
        send_sample(16'sd100, 1'b1);
        send_sample(16'sd300, 1'b0);
        send_sample(16'sd200, 1'b0);
        wait_idle();
        reg_image[REG_DIFF_ORDER] = 16'hFFFD;
        program_filter();
        send_sample(16'sd100, 1'b1);
        send_sample(16'sd300, 1'b0);
        send_sample(-16'sd200, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_series();
        int   run_left;
        logic start;
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default: begin
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
            endcase
            reg_image[REG_DIFF_ORDER] = CFG_DATA_W'($urandom);
            for (int r = 1; r < NUM_REGS; r++) begin
                reg_image[r] = pick_coef(seg);
            end
            program_filter();
            run_left = 0;
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                start = (run_left == 0);
                if (start) begin
                    run_left = int'($urandom_range(MAX_RUN, 1));
                end
                run_left--;
                send_sample(pick_sample(), start);
            end
            wait_idle();
        end
    endtask

    // result checking and receiver stalls
    always @(posedge i_clk) begin : result_check
        filter_out_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: filtered=%0d clipped=%0b", o_filtered, o_clipped);
                fail_count++;
            end else begin
                want = pending_outputs.pop_front();
                results_checked++;
                if (want.clipped) begin
                    clipped_seen++;
                end
                if (o_filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", want.filtered, o_filtered);
                    fail_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, o_clipped);
                    fail_count++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles < WATCHDOG_LIMIT) begin
            quiet_cycles++;
        end else begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("arima_inverse_iir_filter test failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough();
        test_rounding_ties();
        test_saturation();
        test_difference_orders();
        test_random_series();
        $display("Covered %0d items and %0d checked results over %0d register settings.",
                 items_sent, results_checked, configs_loaded);
        $display("Saturated results seen: %0d; handshake patterns: free, sender gaps, stalls, both.",
                 clipped_seen);
        if (fail_count == 0 && pending_outputs.size() == 0) begin
            $display("arima_inverse_iir_filter test passed");
        end else begin
            $display("arima_inverse_iir_filter test failed");
        end
        $finish;
    end

endmodule

>>> arima_inverse_iir_filter.f
+incdir+design
design/aiif_pkg.sv
design/arima_inverse_iir_filter.sv
design/aiif_checker.sv
bench/arima_inverse_iir_filter_tb.sv
